// File: src/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg: shared definitions for the chunked ring packetizer
// Command and status codes, queue word layout and default sizes.
// ----------------------------------------------------------------------------
package crp_pkg;

   localparam int DEF_RING_DEPTH   = 1024;
   localparam int DEF_CHUNK_BYTES  = 256;
   localparam int DEF_PACKET_BYTES = 32;
   localparam int DEF_OUT_DEPTH    = 256;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 11;
   localparam int STATUS_W = 3;
   localparam int RCOUNT_W = 11;
   localparam int OCOUNT_W = 9;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TX  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEQ = 2'd2;

   localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PACKET   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

   typedef enum logic [1:0] {
      CLS_ADD  = 2'd0,
      CLS_TX   = 2'd1,
      CLS_DEQ  = 2'd2,
      CLS_NONE = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic [BYTE_W-1:0]  data_byte;
      logic [LEN_W-1:0]   record_length;
      logic               first_of_record;
   } entry_type;

endpackage

// File: src/crp_ram.sv
// ----------------------------------------------------------------------------
// crp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module crp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/crp_front.sv
// ----------------------------------------------------------------------------
// crp_front: input side of the packetizer
// Accepts request words, classifies the command and queues them.
// ----------------------------------------------------------------------------
module crp_front
   import crp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [LEN_W-1:0]  req_record_length,
   input  logic              req_first_of_record,
   output logic              q_valid,
   output entry_type         q_entry,
   input  logic              q_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push;
   entry_type        new_entry;

   always_comb begin
      new_entry.data_byte       = req_data_byte;
      new_entry.record_length   = req_record_length;
      new_entry.first_of_record = req_first_of_record;
      case (req_command)
         CMD_ADD: new_entry.cls = CLS_ADD;
         CMD_TX:  new_entry.cls = CLS_TX;
         CMD_DEQ: new_entry.cls = CLS_DEQ;
         default: new_entry.cls = CLS_NONE;
      endcase
   end

   assign req_stall = (cnt_ff == CW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_entry   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// File: src/crp_back.sv
// ----------------------------------------------------------------------------
// crp_back: execution side of the packetizer
// Owns the ring and output stores, runs chunk moves and packet reads,
// and drives the result register.
// ----------------------------------------------------------------------------
module crp_back
   import crp_pkg::*;
#(
   parameter int RING_DEPTH   = DEF_RING_DEPTH,
   parameter int CHUNK_BYTES  = DEF_CHUNK_BYTES,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int OUT_DEPTH    = DEF_OUT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  entry_type           q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_packet_byte,
   output logic                rsp_last,
   output logic [RCOUNT_W-1:0] rsp_ring_count,
   output logic [OCOUNT_W-1:0] rsp_output_count
);

   localparam int RA    = $clog2(RING_DEPTH);
   localparam int HA    = RA + 1;
   localparam int FW    = $clog2(RING_DEPTH + 1);
   localparam int HW    = FW + 1;
   localparam int SW    = ((FW > LEN_W) ? FW : LEN_W) + 1;
   localparam int OA    = $clog2(OUT_DEPTH);
   localparam int OH    = OA + 1;
   localparam int OFW   = $clog2(OUT_DEPTH + 1);
   localparam int KEEP  = (CHUNK_BYTES <= OUT_DEPTH) ? CHUNK_BYTES : OUT_DEPTH;
   localparam int KCW   = $clog2(KEEP + 1);
   localparam int PCW   = $clog2(PACKET_BYTES + 1);
   localparam int CW    = (OFW > PCW) ? OFW : PCW;
   localparam int CKW0  = $clog2(CHUNK_BYTES + 1);
   localparam int CKW   = (FW > CKW0) ? FW : CKW0;
   localparam int CHUNK_STEP = CHUNK_BYTES % RING_DEPTH;
   localparam int PKT_STEP   = PACKET_BYTES % OUT_DEPTH;

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_FILL      = 5'b00010,
      S_CHECK     = 5'b00100,
      S_EMIT_RD   = 5'b01000,
      S_EMIT_WAIT = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [RA-1:0]  ring_head_ff, ring_head_in;
   logic [FW-1:0]  ring_fill_ff, ring_fill_in;
   logic [OA-1:0]  out_head_ff, out_head_in;
   logic [OFW-1:0] out_fill_ff, out_fill_in;
   logic           dropping_ff, dropping_in;
   logic [RA-1:0]  rd_addr_ff, rd_addr_in;
   logic [KCW-1:0] fill_cnt_ff, fill_cnt_in;
   logic           wr_pend_ff, wr_pend_in;
   logic [OA-1:0]  wr_idx_ff, wr_idx_in;
   logic [OA-1:0]  emit_addr_ff, emit_addr_in;
   logic [PCW-1:0] emit_cnt_ff, emit_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [RCOUNT_W-1:0] rsp_rcount_ff;
   logic [OCOUNT_W-1:0] rsp_ocount_ff;
   logic                rsp_load;

   logic              slot_free;
   logic [SW-1:0]     len_sum;
   logic [HW-1:0]     wr_sum;
   logic [HA-1:0]     head_sum;
   logic [OH-1:0]     ohead_sum;
   logic              refill_ok;
   logic              pkt_ok;
   logic              fill_issue;
   logic              add_drop;

   logic              ring_we, ring_re;
   logic [RA-1:0]     ring_wa;
   logic [BYTE_W-1:0] ring_rd_data;
   logic              out_we, out_re;
   logic [BYTE_W-1:0] out_rd_data;

   crp_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (q_entry.data_byte),
      .rd_en   (ring_re),
      .rd_addr (rd_addr_ff),
      .rd_data (ring_rd_data)
   );

   crp_ram #(.WIDTH(BYTE_W), .DEPTH(OUT_DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_we),
      .wr_addr (wr_idx_ff),
      .wr_data (ring_rd_data),
      .rd_en   (out_re),
      .rd_addr (emit_addr_ff),
      .rd_data (out_rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign len_sum   = SW'(ring_fill_ff) + SW'(q_entry.record_length);
   assign wr_sum    = HW'(ring_head_ff) + HW'(ring_fill_ff);
   assign ring_wa   = (wr_sum >= HW'(RING_DEPTH)) ? RA'(wr_sum - HW'(RING_DEPTH))
                                                  : RA'(wr_sum);
   assign head_sum  = HA'(ring_head_ff) + HA'(CHUNK_STEP);
   assign ohead_sum = OH'(out_head_ff) + OH'(PKT_STEP);
   assign refill_ok = (out_fill_ff == '0) && (CKW'(ring_fill_ff) >= CKW'(CHUNK_BYTES));
   assign pkt_ok    = (CW'(out_fill_ff) >= CW'(PACKET_BYTES));
   assign fill_issue = (fill_cnt_ff != KCW'(KEEP));
   // a dropped byte: record still being dropped, or ring full
   assign add_drop  = (dropping_ff && !q_entry.first_of_record)
                    || (ring_fill_ff == FW'(RING_DEPTH));

   always_comb begin
      state_in     = state_ff;
      ring_head_in = ring_head_ff;
      ring_fill_in = ring_fill_ff;
      out_head_in  = out_head_ff;
      out_fill_in  = out_fill_ff;
      dropping_in  = dropping_ff;
      rd_addr_in   = rd_addr_ff;
      fill_cnt_in  = fill_cnt_ff;
      wr_pend_in   = 1'b0;
      wr_idx_in    = wr_idx_ff;
      emit_addr_in = emit_addr_ff;
      emit_cnt_in  = emit_cnt_ff;
      q_pop        = 1'b0;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      out_we       = 1'b0;
      out_re       = 1'b0;
      rsp_load     = 1'b0;
      rsp_status_in = ST_NONE;
      rsp_byte_in   = '0;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_entry.cls)
                  CLS_ADD: begin
                     if (slot_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                        if (q_entry.first_of_record && (len_sum > SW'(RING_DEPTH))) begin
                           ring_head_in  = '0;
                           ring_fill_in  = '0;
                           dropping_in   = 1'b1;
                           rsp_status_in = ST_OVERFLOW;
                        end else begin
                           if (q_entry.first_of_record) begin
                              dropping_in = 1'b0;
                           end
                           if (add_drop) begin
                              rsp_status_in = ST_DROPPED;
                           end else begin
                              ring_we       = 1'b1;
                              ring_fill_in  = ring_fill_ff + FW'(1);
                              rsp_status_in = ST_STORED;
                           end
                        end
                     end
                  end
                  CLS_TX: begin
                     q_pop = 1'b1;
                     if (refill_ok) begin
                        fill_cnt_in = '0;
                        rd_addr_in  = ring_head_ff;
                        state_in    = S_FILL;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  CLS_DEQ: begin
                     if (slot_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                        if (pkt_ok) begin
                           out_head_in = (ohead_sum >= OH'(OUT_DEPTH))
                                       ? OA'(ohead_sum - OH'(OUT_DEPTH)) : OA'(ohead_sum);
                           out_fill_in = OFW'(CW'(out_fill_ff) - CW'(PACKET_BYTES));
                        end
                     end
                  end
                  default: begin
                     if (slot_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_FILL: begin
            // read the ring in the cycle before the output store write
            out_we = wr_pend_ff;
            if (fill_issue) begin
               ring_re     = 1'b1;
               rd_addr_in  = (rd_addr_ff == RA'(RING_DEPTH - 1)) ? '0 : rd_addr_ff + RA'(1);
               fill_cnt_in = fill_cnt_ff + KCW'(1);
               wr_pend_in  = 1'b1;
               wr_idx_in   = OA'(fill_cnt_ff);
            end else if (!wr_pend_ff) begin
               out_head_in  = '0;
               out_fill_in  = OFW'(KEEP);
               ring_head_in = (head_sum >= HA'(RING_DEPTH))
                            ? RA'(head_sum - HA'(RING_DEPTH)) : RA'(head_sum);
               ring_fill_in = FW'(CKW'(ring_fill_ff) - CKW'(CHUNK_BYTES));
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pkt_ok) begin
               emit_addr_in = out_head_ff;
               emit_cnt_in  = '0;
               state_in     = S_EMIT_RD;
            end else if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            out_re   = 1'b1;
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_PACKET;
               rsp_byte_in   = out_rd_data;
               rsp_last_in   = (emit_cnt_ff == PCW'(PACKET_BYTES - 1));
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  emit_addr_in = (emit_addr_ff == OA'(OUT_DEPTH - 1))
                               ? '0 : emit_addr_ff + OA'(1);
                  emit_cnt_in  = emit_cnt_ff + PCW'(1);
                  state_in     = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ring_head_ff <= '0;
         ring_fill_ff <= '0;
         out_head_ff  <= '0;
         out_fill_ff  <= '0;
         dropping_ff  <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_head_ff <= ring_head_in;
         ring_fill_ff <= ring_fill_in;
         out_head_ff  <= out_head_in;
         out_fill_ff  <= out_fill_in;
         dropping_ff  <= dropping_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      fill_cnt_ff  <= fill_cnt_in;
      wr_idx_ff    <= wr_idx_in;
      emit_addr_ff <= emit_addr_in;
      emit_cnt_ff  <= emit_cnt_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_rcount_ff <= RCOUNT_W'(ring_fill_in);
         rsp_ocount_ff <= OCOUNT_W'(out_fill_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_packet_byte  = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_ring_count   = rsp_rcount_ff;
   assign rsp_output_count = rsp_ocount_ff;

endmodule

// File: src/chunked_ring_packetizer.sv
// Add, dequeue and unknown commands: one result word each, from the result register.
// Transmit: a chunk move copies min(CHUNK_BYTES, OUT_DEPTH) bytes (one ring
// read per cycle), then each packet word goes through the output store read
// port, then the result register; a transmit with no packet ready gives 1 word.
// Reset clears heads, fill counts, drop flag and queue; store contents stay.
// ----------------------------------------------------------------------------
// chunked_ring_packetizer: two-level ring buffer feeding a packet link
// Front queues and classifies request words; back runs stores and packets.
// ----------------------------------------------------------------------------
module chunked_ring_packetizer
   import crp_pkg::*;
#(
   parameter int RING_DEPTH   = DEF_RING_DEPTH,
   parameter int CHUNK_BYTES  = DEF_CHUNK_BYTES,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES,
   parameter int OUT_DEPTH    = DEF_OUT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [LEN_W-1:0]    req_record_length,
   input  logic                req_first_of_record,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_packet_byte,
   output logic                rsp_last,
   output logic [RCOUNT_W-1:0] rsp_ring_count,
   output logic [OCOUNT_W-1:0] rsp_output_count
);

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   crp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_data_byte       (req_data_byte),
      .req_record_length   (req_record_length),
      .req_first_of_record (req_first_of_record),
      .q_valid             (q_valid),
      .q_entry             (q_entry),
      .q_pop               (q_pop)
   );

   crp_back #(
      .RING_DEPTH   (RING_DEPTH),
      .CHUNK_BYTES  (CHUNK_BYTES),
      .PACKET_BYTES (PACKET_BYTES),
      .OUT_DEPTH    (OUT_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_packet_byte  (rsp_packet_byte),
      .rsp_last         (rsp_last),
      .rsp_ring_count   (rsp_ring_count),
      .rsp_output_count (rsp_output_count)
   );

   a_single_word_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_PACKET) |-> rsp_last)
      else $error("non-packet result word without last");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_PACKET) |-> (rsp_packet_byte == '0))
      else $error("packet byte set on a non-packet word");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_NONE))
      else $error("result status out of range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for chunked_ring_packetizer
// Sends record bytes, transmit, dequeue and unknown commands, keeps its own
// copy of the ring store and the output store to predict each result word,
// and checks the result channel word by word under random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb;
   import crp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int KEEP_BYTES  = (DEF_CHUNK_BYTES <= DEF_OUT_DEPTH) ?
                                DEF_CHUNK_BYTES : DEF_OUT_DEPTH;
   localparam int RING_AW     = $clog2(DEF_RING_DEPTH);
   localparam int OUT_AW      = $clog2(DEF_OUT_DEPTH);
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   packet_byte;
      logic                last;
      logic [RCOUNT_W-1:0] ring_count;
      logic [OCOUNT_W-1:0] output_count;
   } result_word_type;

   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                req_valid           = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command         = CMD_ADD;
   logic [BYTE_W-1:0]   req_data_byte       = '0;
   logic [LEN_W-1:0]    req_record_length   = '0;
   logic                req_first_of_record = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall           = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_packet_byte;
   logic                rsp_last;
   logic [RCOUNT_W-1:0] rsp_ring_count;
   logic [OCOUNT_W-1:0] rsp_output_count;

   // local copy of the block state
   logic [BYTE_W-1:0]   ring_mem [DEF_RING_DEPTH];
   logic [BYTE_W-1:0]   out_mem [DEF_OUT_DEPTH];
   int unsigned         ring_rd   = 0;
   logic [RCOUNT_W-1:0] ring_fill = '0;
   int unsigned         out_rd    = 0;
   logic [OCOUNT_W-1:0] out_fill  = '0;
   logic                drop_mode = 1'b0;

   result_word_type pending_results[$];
   int unsigned     error_count   = 0;
   int unsigned     src_idle_pct  = 13;
   int unsigned     snk_stall_pct = 69;
   int unsigned     src_burst     = 0;
   int unsigned     snk_quiet     = 0;

   chunked_ring_packetizer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_data_byte       (req_data_byte),
      .req_record_length   (req_record_length),
      .req_first_of_record (req_first_of_record),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_packet_byte     (rsp_packet_byte),
      .rsp_last            (rsp_last),
      .rsp_ring_count      (rsp_ring_count),
      .rsp_output_count    (rsp_output_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void push_result(input logic [STATUS_W-1:0] status,
                                       input logic [BYTE_W-1:0] pbyte, input logic last);
      result_word_type w;
      w.status       = status;
      w.packet_byte  = pbyte;
      w.last         = last;
      w.ring_count   = ring_fill;
      w.output_count = out_fill;
      pending_results.push_back(w);
   endfunction

   function automatic void packetize_step(input logic [CMD_W-1:0] cmd,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [LEN_W-1:0] len, input logic first);
      int k;
      case (cmd)
         CMD_ADD: begin
            if (first && int'(ring_fill) + int'(len) > DEF_RING_DEPTH) begin
               ring_rd   = 0;
               ring_fill = '0;
               drop_mode = 1'b1;
               push_result(ST_OVERFLOW, '0, 1'b1);
            end else begin
               if (first) drop_mode = 1'b0;
               if (drop_mode || ring_fill >= DEF_RING_DEPTH) begin
                  push_result(ST_DROPPED, '0, 1'b1);
               end else begin
                  ring_mem[RING_AW'((ring_rd + ring_fill) % DEF_RING_DEPTH)] = data;
                  ring_fill = ring_fill + RCOUNT_W'(1);
                  push_result(ST_STORED, '0, 1'b1);
               end
            end
         end
         CMD_TX: begin
            // move one chunk only into an empty output store
            if (out_fill == 0 && ring_fill >= DEF_CHUNK_BYTES) begin
               for (k = 0; k < KEEP_BYTES; k++)
                  out_mem[OUT_AW'(k)] = ring_mem[RING_AW'((ring_rd + k) % DEF_RING_DEPTH)];
               out_rd    = 0;
               out_fill  = OCOUNT_W'(KEEP_BYTES);
               ring_rd   = (ring_rd + DEF_CHUNK_BYTES) % DEF_RING_DEPTH;
               ring_fill = ring_fill - RCOUNT_W'(DEF_CHUNK_BYTES);
            end
            if (out_fill >= DEF_PACKET_BYTES) begin
               for (k = 0; k < DEF_PACKET_BYTES; k++)
                  push_result(ST_PACKET, out_mem[OUT_AW'((out_rd + k) % DEF_OUT_DEPTH)],
                              k == DEF_PACKET_BYTES - 1);
            end else begin
               push_result(ST_NONE, '0, 1'b1);
            end
         end
         CMD_DEQ: begin
            if (out_fill >= DEF_PACKET_BYTES) begin
               out_rd   = (out_rd + DEF_PACKET_BYTES) % DEF_OUT_DEPTH;
               out_fill = out_fill - OCOUNT_W'(DEF_PACKET_BYTES);
            end
            push_result(ST_NONE, '0, 1'b1);
         end
         default: begin
            push_result(ST_NONE, '0, 1'b1);
         end
      endcase
   endfunction

   // Valid is left high after a word so the next word never lowers and raises it
   // in the same step.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                            input logic [LEN_W-1:0] len, input logic first);
      if (src_burst == 0 && $urandom_range(0, 31) == 0) src_burst = $urandom_range(8, 40);
      if (src_burst > 0) begin
         src_burst--;
      end else begin
         while ($urandom_range(0, 99) < src_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_data_byte       <= data;
      req_record_length   <= len;
      req_first_of_record <= first;
      do @(posedge clock); while (req_stall);
      packetize_step(cmd, data, len, first);
   endtask

   always @(posedge clock) begin
      if (snk_quiet > 0) begin
         snk_quiet--;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < snk_stall_pct);
         if ($urandom_range(0, 63) == 0) snk_quiet = $urandom_range(8, 40);
      end
   end

   function automatic void check_field(input string field, input logic [15:0] expv,
                                       input logic [15:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, expv, actv);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: word with none expected, status expected none actual %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            exp_w = pending_results.pop_front();
            check_field("status", 16'(exp_w.status), 16'(rsp_status));
            check_field("packet_byte", 16'(exp_w.packet_byte), 16'(rsp_packet_byte));
            check_field("last", 16'(exp_w.last), 16'(rsp_last));
            check_field("ring_count", 16'(exp_w.ring_count), 16'(rsp_ring_count));
            check_field("output_count", 16'(exp_w.output_count), 16'(rsp_output_count));
         end
      end
   end

   task automatic test_command_edges();
      send_word(CMD_TX, 8'h00, 11'd0, 1'b0);
      send_word(CMD_DEQ, 8'h00, 11'd0, 1'b0);
      send_word(CMD_UNKNOWN, 8'hFF, 11'd2047, 1'b1);
      send_word(CMD_UNKNOWN, 8'h00, 11'd0, 1'b0);
   endtask

   task automatic test_record_edges();
      send_word(CMD_ADD, 8'h00, 11'd0, 1'b1);       // zero length passes
      send_word(CMD_ADD, 8'hFF, 11'd2047, 1'b0);    // length ignored mid record
      send_word(CMD_ADD, 8'h11, 11'd2047, 1'b1);    // overflow, clear
      send_word(CMD_ADD, 8'hA5, 11'd3, 1'b0);
      send_word(CMD_ADD, 8'h5A, 11'd0, 1'b0);
      send_word(CMD_ADD, 8'h22, 11'd1025, 1'b1);    // overflow on empty ring
      send_word(CMD_ADD, 8'h5A, 11'd1024, 1'b1);    // fits exactly
      send_word(CMD_ADD, 8'hC3, 11'd1023, 1'b1);
      send_word(CMD_ADD, 8'h3C, 11'd1024, 1'b1);    // two past capacity
      send_word(CMD_ADD, 8'h77, 11'd1, 1'b0);
      send_word(CMD_ADD, 8'hFF, 11'd1, 1'b1);
      send_word(CMD_TX, 8'hFF, 11'd2047, 1'b1);
      send_word(CMD_DEQ, 8'hFF, 11'd2047, 1'b1);
   endtask

   // Fill the ring with well-formed records up to a target byte count.
   task automatic test_chunk_fill(input int unsigned src_pct, input int unsigned snk_pct,
                                  input int unsigned target);
      int unsigned room;
      int unsigned len;
      int unsigned j;
      src_idle_pct  = src_pct;
      snk_stall_pct = snk_pct;
      while (ring_fill < RCOUNT_W'(target)) begin
         // transmit below a full chunk gives no packet
         if ($urandom_range(0, 7) == 0)
            send_word(CMD_TX, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom));
         room = target - 32'(ring_fill);
         len  = $urandom_range(1, 64);
         if (len > room) len = room;
         for (j = 0; j < len; j++)
            send_word(CMD_ADD, BYTE_W'($urandom),
                      (j == 0) ? LEN_W'(len) : LEN_W'($urandom_range(0, 2047)), j == 0);
      end
   endtask

   // Send transmit and dequeue pairs; a repeated transmit resends the same packet.
   task automatic test_packet_drain(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_pairs);
      int unsigned j;
      src_idle_pct  = src_pct;
      snk_stall_pct = snk_pct;
      for (j = 0; j < n_pairs; j++) begin
         send_word(CMD_TX, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom));
         if ($urandom_range(0, 3) == 0)
            send_word(CMD_TX, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom));
         send_word(CMD_DEQ, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_command_edges();
      test_record_edges();
      test_chunk_fill(13, 69, DEF_CHUNK_BYTES / 2);
      test_chunk_fill(69, 13, DEF_CHUNK_BYTES);
      test_packet_drain(69, 13, 4);
      test_packet_drain(0, 0, 5);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
